### rtl/md5de_pkg.sv
// ----------------------------------------------------------------------------
// md5de_pkg
// Shared types, constants and round tables for the md5 digest engine.
// ----------------------------------------------------------------------------
package md5de_pkg;

    // md5 chaining initial values
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [2:0]  FULL_COUNT = 3'd4;
    localparam logic [3:0]  LAST_SLOT  = 4'd15;
    localparam logic [3:0]  LEN_SLOT   = 4'd14;
    localparam logic [5:0]  LAST_ROUND = 6'd63;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LENLO,
        ST_LENHI,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_DONE
    } ctrl_state_t;

    // source of a word written into the block buffer
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LENLO,
        SRC_LENHI
    } put_src_t;

    typedef struct packed {
        logic     put_en;
        put_src_t put_src;
        logic     len_en;
        logic     load;
        logic     round_en;
        logic     final_en;
        logic     done;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] pos;
        logic       full_word;
        logic       rnd_last;
    } dp_status_t;

    // buffer word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    msg_index = lo;
            2'd1:    msg_index = 4'((lo << 2) + lo + 4'd1);
            2'd2:    msg_index = 4'((lo << 1) + lo + 4'd5);
            default: msg_index = 4'((lo << 3) - lo);
        endcase
    endfunction

    // left rotate amount of a round
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        case ({r[5:4], r[1:0]})
            4'd0:    rot_amount = 5'd7;
            4'd1:    rot_amount = 5'd12;
            4'd2:    rot_amount = 5'd17;
            4'd3:    rot_amount = 5'd22;
            4'd4:    rot_amount = 5'd5;
            4'd5:    rot_amount = 5'd9;
            4'd6:    rot_amount = 5'd14;
            4'd7:    rot_amount = 5'd20;
            4'd8:    rot_amount = 5'd4;
            4'd9:    rot_amount = 5'd11;
            4'd10:   rot_amount = 5'd16;
            4'd11:   rot_amount = 5'd23;
            4'd12:   rot_amount = 5'd6;
            4'd13:   rot_amount = 5'd10;
            4'd14:   rot_amount = 5'd15;
            default: rot_amount = 5'd21;
        endcase
    endfunction

    // sine-derived round constants
    function automatic logic [31:0] round_const(input logic [5:0] r);
        case (r)
            6'd0:  round_const = 32'hd76aa478;
            6'd1:  round_const = 32'he8c7b756;
            6'd2:  round_const = 32'h242070db;
            6'd3:  round_const = 32'hc1bdceee;
            6'd4:  round_const = 32'hf57c0faf;
            6'd5:  round_const = 32'h4787c62a;
            6'd6:  round_const = 32'ha8304613;
            6'd7:  round_const = 32'hfd469501;
            6'd8:  round_const = 32'h698098d8;
            6'd9:  round_const = 32'h8b44f7af;
            6'd10: round_const = 32'hffff5bb1;
            6'd11: round_const = 32'h895cd7be;
            6'd12: round_const = 32'h6b901122;
            6'd13: round_const = 32'hfd987193;
            6'd14: round_const = 32'ha679438e;
            6'd15: round_const = 32'h49b40821;
            6'd16: round_const = 32'hf61e2562;
            6'd17: round_const = 32'hc040b340;
            6'd18: round_const = 32'h265e5a51;
            6'd19: round_const = 32'he9b6c7aa;
            6'd20: round_const = 32'hd62f105d;
            6'd21: round_const = 32'h02441453;
            6'd22: round_const = 32'hd8a1e681;
            6'd23: round_const = 32'he7d3fbc8;
            6'd24: round_const = 32'h21e1cde6;
            6'd25: round_const = 32'hc33707d6;
            6'd26: round_const = 32'hf4d50d87;
            6'd27: round_const = 32'h455a14ed;
            6'd28: round_const = 32'ha9e3e905;
            6'd29: round_const = 32'hfcefa3f8;
            6'd30: round_const = 32'h676f02d9;
            6'd31: round_const = 32'h8d2a4c8a;
            6'd32: round_const = 32'hfffa3942;
            6'd33: round_const = 32'h8771f681;
            6'd34: round_const = 32'h6d9d6122;
            6'd35: round_const = 32'hfde5380c;
            6'd36: round_const = 32'ha4beea44;
            6'd37: round_const = 32'h4bdecfa9;
            6'd38: round_const = 32'hf6bb4b60;
            6'd39: round_const = 32'hbebfbc70;
            6'd40: round_const = 32'h289b7ec6;
            6'd41: round_const = 32'heaa127fa;
            6'd42: round_const = 32'hd4ef3085;
            6'd43: round_const = 32'h04881d05;
            6'd44: round_const = 32'hd9d4d039;
            6'd45: round_const = 32'he6db99e5;
            6'd46: round_const = 32'h1fa27cf8;
            6'd47: round_const = 32'hc4ac5665;
            6'd48: round_const = 32'hf4292244;
            6'd49: round_const = 32'h432aff97;
            6'd50: round_const = 32'hab9423a7;
            6'd51: round_const = 32'hfc93a039;
            6'd52: round_const = 32'h655b59c3;
            6'd53: round_const = 32'h8f0ccc92;
            6'd54: round_const = 32'hffeff47d;
            6'd55: round_const = 32'h85845dd1;
            6'd56: round_const = 32'h6fa87e4f;
            6'd57: round_const = 32'hfe2ce6e0;
            6'd58: round_const = 32'ha3014314;
            6'd59: round_const = 32'h4e0811a1;
            6'd60: round_const = 32'hf7537e82;
            6'd61: round_const = 32'hbd3af235;
            6'd62: round_const = 32'h2ad7d2bb;
            default: round_const = 32'heb86d391;
        endcase
    endfunction

endpackage

### rtl/md5de_dp.sv
// ----------------------------------------------------------------------------
// md5de_dp
// Datapath: block buffer, length counter, one md5 round per cycle and the
// chaining words, driven by commands from the controller.
// ----------------------------------------------------------------------------
module md5de_dp
    import md5de_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [63:0] m_digest_low,
    output logic [63:0] m_digest_high
);

    logic [31:0] buf_reg [16];
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] km_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] ch_reg [4];
    logic [31:0] ch_next [4];
    logic [63:0] dig_lo_reg, dig_hi_reg;

    logic [2:0]  eff_cnt;
    logic [31:0] in_word;
    logic [31:0] put_data;
    logic [31:0] f_val;
    logic [31:0] t_sum;
    logic [31:0] t_rot;
    logic [4:0]  shamt;
    logic [5:0]  rnd_fetch;

    // effective byte count of the incoming word
    assign eff_cnt = (!s_last || s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;

    // short final word gets the pad byte right after its data
    always_comb begin
        case (eff_cnt)
            3'd0:    in_word = {24'h0, PAD_BYTE};
            3'd1:    in_word = {16'h0, PAD_BYTE, s_message_word[7:0]};
            3'd2:    in_word = {8'h0, PAD_BYTE, s_message_word[15:0]};
            3'd3:    in_word = {PAD_BYTE, s_message_word[23:0]};
            default: in_word = s_message_word;
        endcase
    end

    // word written into the buffer
    always_comb begin
        case (cmd.put_src)
            SRC_INPUT: put_data = in_word;
            SRC_PAD80: put_data = {24'h0, PAD_BYTE};
            SRC_LENLO: put_data = len_reg[31:0];
            SRC_LENHI: put_data = len_reg[63:32];
            default:   put_data = 32'h0;
        endcase
    end

    // buffer write
    always_ff @(posedge aclk) begin
        if (cmd.put_en) begin
            buf_reg[pos_reg] <= put_data;
        end
    end

    // round function and rotate
    always_comb begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        shamt = rot_amount(rnd_reg);
        t_sum = f_val + a_reg + km_reg;
        t_rot = (t_sum << shamt) | (t_sum >> (6'd32 - {1'b0, shamt}));
    end

    // constant plus message word, fetched one round ahead
    assign rnd_fetch = cmd.load ? 6'd0 : rnd_reg + 6'd1;

    // next state of counters and working words
    always_comb begin
        pos_next = pos_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        for (int i = 0; i < 4; i++) begin
            ch_next[i] = ch_reg[i];
        end
        if (cmd.put_en) begin
            pos_next = pos_reg + 4'd1;
        end
        if (cmd.len_en) begin
            len_next = len_reg + {58'h0, eff_cnt, 3'b000};
        end
        if (cmd.load) begin
            rnd_next = 6'd0;
            a_next   = ch_reg[0];
            b_next   = ch_reg[1];
            c_next   = ch_reg[2];
            d_next   = ch_reg[3];
        end
        if (cmd.round_en) begin
            rnd_next = rnd_reg + 6'd1;
            a_next   = d_reg;
            b_next   = b_reg + t_rot;
            c_next   = b_reg;
            d_next   = c_reg;
        end
        if (cmd.final_en) begin
            ch_next[0] = ch_reg[0] + a_reg;
            ch_next[1] = ch_reg[1] + b_reg;
            ch_next[2] = ch_reg[2] + c_reg;
            ch_next[3] = ch_reg[3] + d_reg;
        end
        if (cmd.done) begin
            len_next   = 64'h0;
            ch_next[0] = IV_A;
            ch_next[1] = IV_B;
            ch_next[2] = IV_C;
            ch_next[3] = IV_D;
        end
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 4'd0;
            len_reg  <= 64'h0;
            rnd_reg  <= 6'd0;
            a_reg    <= 32'h0;
            b_reg    <= 32'h0;
            c_reg    <= 32'h0;
            d_reg    <= 32'h0;
            ch_reg[0] <= IV_A;
            ch_reg[1] <= IV_B;
            ch_reg[2] <= IV_C;
            ch_reg[3] <= IV_D;
        end else begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            d_reg   <= d_next;
            for (int i = 0; i < 4; i++) begin
                ch_reg[i] <= ch_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.round_en) begin
            km_reg <= round_const(rnd_fetch) + buf_reg[msg_index(rnd_fetch)];
        end
        if (cmd.done) begin
            dig_lo_reg <= {ch_reg[1], ch_reg[0]};
            dig_hi_reg <= {ch_reg[3], ch_reg[2]};
        end
    end

    assign m_digest_low     = dig_lo_reg;
    assign m_digest_high    = dig_hi_reg;
    assign status.pos       = pos_reg;
    assign status.full_word = (eff_cnt == FULL_COUNT);
    assign status.rnd_last  = (rnd_reg == LAST_ROUND);

    // a block starts only when the buffer has wrapped
    a_load_at_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> pos_reg == 4'd0)
        else $error("round load with partly filled buffer");

    // no buffer write while rounds read it
    a_no_put_in_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round_en |-> !cmd.put_en)
        else $error("buffer written during rounds");

    // chaining words reload after a digest
    a_iv_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |=> ch_reg[0] == IV_A && ch_reg[3] == IV_D && len_reg == 64'h0)
        else $error("chaining words not reloaded");

endmodule

### rtl/md5de_ctrl.sv
// ----------------------------------------------------------------------------
// md5de_ctrl
// Controller: takes message words, sequences padding, length words, the
// 64 rounds of each block and the digest handoff.
// ----------------------------------------------------------------------------
module md5de_ctrl
    import md5de_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    ctrl_state_t ret_reg, ret_next;
    logic        mval_reg, mval_next;

    // next state and datapath commands
    always_comb begin
        ctrl_state_t follow;
        follow     = ST_IDLE;
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.put_en  = 1'b1;
                    cmd.put_src = SRC_INPUT;
                    cmd.len_en  = 1'b1;
                    if (!s_last) begin
                        follow = ST_IDLE;
                    end else if (status.full_word) begin
                        follow = ST_PAD80;
                    end else begin
                        follow = ST_PADZ;
                    end
                end
            end
            ST_PAD80: begin
                cmd.put_en  = 1'b1;
                cmd.put_src = SRC_PAD80;
                follow      = ST_PADZ;
            end
            ST_PADZ: begin
                if (status.pos == LEN_SLOT) begin
                    state_next = ST_LENLO;
                end else begin
                    cmd.put_en  = 1'b1;
                    cmd.put_src = SRC_ZERO;
                    follow      = ST_PADZ;
                end
            end
            ST_LENLO: begin
                cmd.put_en  = 1'b1;
                cmd.put_src = SRC_LENLO;
                follow      = ST_LENHI;
            end
            ST_LENHI: begin
                cmd.put_en  = 1'b1;
                cmd.put_src = SRC_LENHI;
                follow      = ST_DONE;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (status.rnd_last) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.final_en = 1'b1;
                state_next   = ret_reg;
            end
            ST_DONE: begin
                if (!mval_reg || m_ready) begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a write into the last slot starts the rounds
        if (cmd.put_en) begin
            if (status.pos == LAST_SLOT) begin
                state_next = ST_LOAD;
                ret_next   = follow;
            end else begin
                state_next = follow;
            end
        end
    end

    // result valid flag
    always_comb begin
        mval_next = mval_reg;
        if (cmd.done) begin
            mval_next = 1'b1;
        end else if (m_ready) begin
            mval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_valid = mval_reg;

    // high length word always closes a block
    a_lenhi_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LENHI |=> state_reg == ST_LOAD && ret_reg == ST_DONE)
        else $error("length word did not start the final block");

    // a pending digest is never overwritten
    a_done_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |-> !mval_reg || m_ready)
        else $error("digest overwritten while pending");

    // the last round hands over to the chaining add
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND && status.rnd_last |=> state_reg == ST_FINAL)
        else $error("round sequence overran");

endmodule

### rtl/md5_digest_engine_unit.sv
// ----------------------------------------------------------------------------
// md5_digest_engine_unit
// md5 digest over a stream of little-endian 32-bit message words.
//
// channel   direction  ports
// s_        in         s_message_word[31:0], s_byte_count[2:0], s_last
// m_        out        m_digest_low[63:0], m_digest_high[63:0]
//
// a word is taken while the engine is idle; each full block of 16 words
// then costs a load, 64 rounds at one round per cycle and a chaining
// add, during which no request is taken.
// the final word adds pad and length writes, plus one more block when
// the length does not fit.
// aresetn is synchronous; it loads the md5 initial values and clears the
// length; the block buffer itself needs no reset.
// a digest waiting on m_ready stalls only the end of the next message.
// ----------------------------------------------------------------------------
module md5_digest_engine_unit
    import md5de_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_low,
    output logic [63:0] m_digest_high
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    md5de_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // buffer, rounds and chaining words
    md5de_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_last         (s_last),
        .cmd            (cmd),
        .status         (status),
        .m_digest_low   (m_digest_low),
        .m_digest_high  (m_digest_high)
    );

endmodule

### dv/md5_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// Watches both channels of the md5 digest engine, keeps its own md5 model of
// the message stream and compares every digest with the predicted one.
// ----------------------------------------------------------------------------
module md5_digest_checker
    import md5de_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_digest_low,
    input  logic [63:0] m_digest_high,
    output int unsigned fail_count,
    output int unsigned pending_count
);

    typedef struct {
        logic [63:0] low;
        logic [63:0] high;
    } digest_t;

    // md5 sine table and per-round rotate amounts
    logic [31:0] sine_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int unsigned rot_by [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // model state
    logic [31:0] chain [4];
    logic [31:0] msg_blk [16];
    logic [3:0]  wr_pos;
    logic [63:0] msg_bits;
    digest_t     digest_q [$];

    task automatic clear_message();
        chain[0] = IV_A;
        chain[1] = IV_B;
        chain[2] = IV_C;
        chain[3] = IV_D;
        wr_pos   = '0;
        msg_bits = '0;
    endtask

    // 64 rounds over the buffered block, then the chaining add
    task automatic compress_block();
        logic [31:0] a, b, c, d, f, t;
        int unsigned g, s;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = f + a + sine_k[r] + msg_blk[g];
            s = rot_by[(r / 16) * 4 + r % 4];
            t = (t << s) | (t >> (32 - s));
            a = d;
            d = c;
            c = b;
            b = b + t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endtask

    task automatic store_word(input logic [31:0] w);
        msg_blk[wr_pos] = w;
        wr_pos = wr_pos + 4'd1;
        if (wr_pos == 4'd0)
            compress_block();
    endtask

    // one accepted request: buffer it, and on the last word pad and finish
    task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt,
                               input logic is_last);
        logic [2:0]  eff;
        logic [31:0] keep;
        digest_t     dg;
        eff = (!is_last || cnt > FULL_COUNT) ? FULL_COUNT : cnt;
        msg_bits = msg_bits + 64'(eff) * 64'd8;
        if (!is_last) begin
            store_word(w);
            return;
        end
        if (eff < FULL_COUNT) begin
            keep = (32'h1 << (8 * eff)) - 32'h1;
            store_word((w & keep) | (32'(PAD_BYTE) << (8 * eff)));
        end else begin
            store_word(w);
            store_word(32'(PAD_BYTE));
        end
        // no room for the length: zero fill into an extra block
        if (wr_pos > LEN_SLOT)
            while (wr_pos != 4'd0)
                store_word('0);
        while (wr_pos < LEN_SLOT)
            store_word('0);
        store_word(msg_bits[31:0]);
        store_word(msg_bits[63:32]);
        dg.low  = {chain[1], chain[0]};
        dg.high = {chain[3], chain[2]};
        digest_q.push_back(dg);
        clear_message();
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
        clear_message();
    end

    // compare digests first, then fold in the request of this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_message();
            digest_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest low %h high %h",
                             $time, m_digest_low, m_digest_high);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_digest_low !== digest_q[0].low ||
                        m_digest_high !== digest_q[0].high) begin
                        if (m_digest_low !== digest_q[0].low)
                            $display("%0t: digest_low expected %h, got %h",
                                     $time, digest_q[0].low, m_digest_low);
                        if (m_digest_high !== digest_q[0].high)
                            $display("%0t: digest_high expected %h, got %h",
                                     $time, digest_q[0].high, m_digest_high);
                        fail_count <= fail_count + 1;
                    end
                    void'(digest_q.pop_front());
                end
            end
            if (s_valid && s_ready)
                absorb_word(s_message_word, s_byte_count, s_last);
        end
        pending_count <= digest_q.size();
    end

endmodule

### dv/tb_md5_digest_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_digest_engine_unit
// Drives message streams into the md5 digest engine: a few directed messages,
// a long receiver stall that backs up the input, then random messages with
// lengths around the padding boundaries, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_md5_digest_engine_unit;
    import md5de_pkg::*;

    localparam int unsigned WORD_TARGET    = 950;
    localparam int unsigned QUIET_FROM     = 800;
    localparam int unsigned RX_HOLD_CYCLES = 1500;
    localparam int unsigned DRAIN_CYCLES   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 6000;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_message_word = '0;
    logic [2:0]  s_byte_count   = '0;
    logic        s_last         = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [63:0] m_digest_low;
    logic [63:0] m_digest_high;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned words_sent  = 0;
    int unsigned idle_cycles = 0;
    logic        tx_idle     = 1'b1;
    logic        rx_idle     = 1'b1;
    logic        hold_req    = 1'b0;
    logic        hold_served = 1'b0;

    md5_digest_engine_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_low   (m_digest_low),
        .m_digest_high  (m_digest_high)
    );

    md5_digest_checker digest_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_low   (m_digest_low),
        .m_digest_high  (m_digest_high),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always #5 aclk = ~aclk;

    // watchdog on cycles with no request or digest moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb_md5_digest_engine_unit: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // digest receiver: random stall bursts and one long hold when asked
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       pick_word = '0;
            1:       pick_word = '1;
            default: pick_word = $urandom;
        endcase
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt,
                             input logic is_last);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_message_word <= w;
        s_byte_count   <= cnt;
        s_last         <= is_last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_message(input int unsigned n_words,
                                input logic [2:0] last_cnt);
        for (int unsigned i = 1; i < n_words; i++)
            send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
        send_word(pick_word(), last_cnt, 1'b1);
    endtask

    initial begin
        int unsigned n_words;
        logic [2:0]  last_cnt;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, short tails, oversized counts
        send_word(32'h00000000, 3'd0, 1'b1);
        send_word(32'h00636261, 3'd3, 1'b1);
        send_word(32'hffffffff, 3'd4, 1'b1);
        send_word(32'h12345678, 3'd7, 1'b1);
        send_word(32'hffffffff, 3'd5, 1'b1);
        send_word(32'h80000001, 3'd6, 1'b1);
        send_word(32'hdeadbeef, 3'd1, 1'b0);
        send_word(32'hffffffff, 3'd2, 1'b1);
        send_word(32'h00000000, 3'd0, 1'b0);
        send_word(32'hffffffff, 3'd1, 1'b1);
        // full last word at slot 13: length spills into an extra block
        send_message(14, 3'd4);

        // long receiver hold while short messages keep coming
        hold_req <= 1'b1;
        repeat (8) send_message($urandom_range(1, 3), 3'($urandom_range(0, 4)));

        // random messages, biased toward the padding boundaries
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= QUIET_FROM) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n_words = $urandom_range(1, 20);
                6, 7:    n_words = $urandom_range(13, 17) + 16 * $urandom_range(0, 1);
                default: n_words = $urandom_range(1, 48);
            endcase
            if ($urandom_range(0, 9) < 8)
                last_cnt = 3'($urandom_range(0, 4));
            else
                last_cnt = 3'($urandom_range(5, 7));
            send_message(n_words, last_cnt);
        end
        s_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("tb_md5_digest_engine_unit: PASS");
        else
            $display("tb_md5_digest_engine_unit: FAIL");
        $finish;
    end

endmodule
